@@ rtl/qcm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qcm_pkg
// Shared types, widths and iteration steps for the quad cell metrics pipeline.
// ----------------------------------------------------------------------------
package qcm_pkg;

	// square root: 66-bit radicand, 33-bit root, one root bit per step
	localparam int SQ_W     = 66;
	localparam int RT_W     = 33;
	localparam int RM_W     = 36;
	localparam int SQ_STEPS = RT_W;
	localparam int SQ_PER   = 3;
	localparam int SQ_STG   = (SQ_STEPS + SQ_PER - 1) / SQ_PER;

	// restoring division, one quotient bit per step
	localparam int DV_W     = 40;
	localparam int DQ_W     = 32;
	localparam int DV_PER   = 3;
	localparam int UN_STEPS = 17;
	localparam int UN_STG   = (UN_STEPS + DV_PER - 1) / DV_PER;
	localparam int IV_STEPS = 32;
	localparam int IV_STG   = (IV_STEPS + DV_PER - 1) / DV_PER;

	localparam logic [31:0] SAT_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] SAT_MIN = 32'h8000_0000;

	typedef struct packed {
		logic signed [31:0] p00_x;
		logic signed [31:0] p00_y;
		logic signed [31:0] p10_x;
		logic signed [31:0] p10_y;
		logic signed [31:0] p01_x;
		logic signed [31:0] p01_y;
		logic signed [31:0] p11_x;
		logic signed [31:0] p11_y;
	} corners_t;

	typedef struct packed {
		logic signed [31:0] cen_x;
		logic signed [31:0] cen_y;
		logic [31:0]        area;
	} cell_pay_t;

	typedef struct packed {
		cell_pay_t          pay;
		logic signed [32:0] xx;
		logic signed [32:0] xy;
		logic signed [32:0] ex;
		logic signed [32:0] ey;
		logic [SQ_W-1:0]    rad_x;
		logic [SQ_W-1:0]    rad_e;
	} geo_t;

	typedef struct packed {
		cell_pay_t          pay;
		logic signed [32:0] xx;
		logic signed [32:0] xy;
		logic signed [32:0] ex;
		logic signed [32:0] ey;
		logic [RT_W-1:0]    len_x;
		logic [RT_W-1:0]    len_e;
	} lens_t;

	typedef struct packed {
		cell_pay_t          pay;
		logic [31:0]        len_x;
		logic [31:0]        len_e;
		logic signed [17:0] uxx;
		logic signed [17:0] uxy;
		logic signed [17:0] uex;
		logic signed [17:0] uey;
	} units_t;

	typedef struct packed {
		units_t           u;
		logic [3:0][31:0] inv;
		logic             degen;
	} res_t;

	typedef struct packed {
		logic [SQ_W-1:0] rad;
		logic [RM_W-1:0] rem;
		logic [RT_W-1:0] root;
	} sqrt_st_t;

	typedef struct packed {
		logic [DV_W-1:0] rem;
		logic [DV_W-1:0] den;
		logic [DQ_W-1:0] num;
		logic [DQ_W-1:0] q;
	} div_st_t;

	// one root bit of a digit-by-digit square root
	function automatic sqrt_st_t sqrt_step(sqrt_st_t s);
		sqrt_st_t        r;
		logic [RM_W-1:0] rem2;
		logic [RM_W-1:0] trial;
		r     = s;
		rem2  = {s.rem[RM_W-3:0], s.rad[SQ_W-1:SQ_W-2]};
		trial = RM_W'({s.root, 2'b01});
		r.rad = {s.rad[SQ_W-3:0], 2'b00};
		if (rem2 >= trial) begin
			r.rem  = rem2 - trial;
			r.root = {s.root[RT_W-2:0], 1'b1};
		end else begin
			r.rem  = rem2;
			r.root = {s.root[RT_W-2:0], 1'b0};
		end
		return r;
	endfunction

	// one quotient bit of a restoring division
	function automatic div_st_t div_step(div_st_t s);
		div_st_t         r;
		logic [DV_W-1:0] rem2;
		r     = s;
		rem2  = {s.rem[DV_W-2:0], s.num[DQ_W-1]};
		r.num = {s.num[DQ_W-2:0], 1'b0};
		if (rem2 >= s.den) begin
			r.rem = rem2 - s.den;
			r.q   = {s.q[DQ_W-2:0], 1'b1};
		end else begin
			r.rem = rem2;
			r.q   = {s.q[DQ_W-2:0], 1'b0};
		end
		return r;
	endfunction

endpackage

@@ rtl/qcm_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qcm_front
// Edge vectors, centroid, squared edge lengths and cell area in four stages.
// ----------------------------------------------------------------------------
module qcm_front import qcm_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     en,
	input  logic     in_vld,
	input  corners_t in_data,
	output logic     out_vld,
	output geo_t     out_data
);

	logic [3:0] vld_s;

	logic signed [32:0] xx_s1, xy_s1, ex_s1, ey_s1;
	logic signed [33:0] sumx_s1, sumy_s1;

	logic signed [65:0] pab_s2, pba_s2, sqxx_s2, sqxy_s2, sqex_s2, sqey_s2;
	logic signed [32:0] xx_s2, xy_s2, ex_s2, ey_s2;
	logic signed [31:0] cenx_s2, ceny_s2;

	logic [SQ_W-1:0]    radx_s3, rade_s3;
	logic signed [66:0] cross_s3;
	logic signed [32:0] xx_s3, xy_s3, ex_s3, ey_s3;
	logic signed [31:0] cenx_s3, ceny_s3;

	geo_t geo_s4;

	logic [66:0] cross_mag;
	logic [51:0] area_rnd;
	logic [31:0] area_sat;

	function automatic logic signed [32:0] diff(logic signed [31:0] a, logic signed [31:0] b);
		return 33'(a) - 33'(b);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[2:0], in_vld};
		end
	end

	always_comb begin
		cross_mag = cross_s3[66] ? 67'(-cross_s3) : 67'(cross_s3);
		// round half up from Q32.32 to Q16.16
		area_rnd  = 52'(cross_mag[66:16]) + 52'(cross_mag[15]);
		area_sat  = (area_rnd > 52'(SAT_MAX)) ? SAT_MAX : area_rnd[31:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xx_s1   <= diff(in_data.p10_x, in_data.p00_x);
			xy_s1   <= diff(in_data.p10_y, in_data.p00_y);
			ex_s1   <= diff(in_data.p01_x, in_data.p00_x);
			ey_s1   <= diff(in_data.p01_y, in_data.p00_y);
			sumx_s1 <= 34'(in_data.p00_x) + 34'(in_data.p10_x) + 34'(in_data.p01_x)
				+ 34'(in_data.p11_x);
			sumy_s1 <= 34'(in_data.p00_y) + 34'(in_data.p10_y) + 34'(in_data.p01_y)
				+ 34'(in_data.p11_y);

			pab_s2  <= 66'(xx_s1) * 66'(ey_s1);
			pba_s2  <= 66'(ex_s1) * 66'(xy_s1);
			sqxx_s2 <= 66'(xx_s1) * 66'(xx_s1);
			sqxy_s2 <= 66'(xy_s1) * 66'(xy_s1);
			sqex_s2 <= 66'(ex_s1) * 66'(ex_s1);
			sqey_s2 <= 66'(ey_s1) * 66'(ey_s1);
			xx_s2   <= xx_s1;
			xy_s2   <= xy_s1;
			ex_s2   <= ex_s1;
			ey_s2   <= ey_s1;
			// arithmetic shift gives the floor of the mean
			cenx_s2 <= 32'(sumx_s1 >>> 2);
			ceny_s2 <= 32'(sumy_s1 >>> 2);

			radx_s3  <= $unsigned(sqxx_s2) + $unsigned(sqxy_s2);
			rade_s3  <= $unsigned(sqex_s2) + $unsigned(sqey_s2);
			cross_s3 <= 67'(pab_s2) - 67'(pba_s2);
			xx_s3    <= xx_s2;
			xy_s3    <= xy_s2;
			ex_s3    <= ex_s2;
			ey_s3    <= ey_s2;
			cenx_s3  <= cenx_s2;
			ceny_s3  <= ceny_s2;

			geo_s4.pay.cen_x <= cenx_s3;
			geo_s4.pay.cen_y <= ceny_s3;
			geo_s4.pay.area  <= area_sat;
			geo_s4.xx        <= xx_s3;
			geo_s4.xy        <= xy_s3;
			geo_s4.ex        <= ex_s3;
			geo_s4.ey        <= ey_s3;
			geo_s4.rad_x     <= radx_s3;
			geo_s4.rad_e     <= rade_s3;
		end
	end

	assign out_vld  = vld_s[3];
	assign out_data = geo_s4;

endmodule

@@ rtl/qcm_len.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qcm_len
// Pipelined integer square roots giving both edge lengths.
// ----------------------------------------------------------------------------
module qcm_len import qcm_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  logic  in_vld,
	input  geo_t  in_data,
	output logic  out_vld,
	output lens_t out_data
);

	typedef struct packed {
		cell_pay_t          pay;
		logic signed [32:0] xx;
		logic signed [32:0] xy;
		logic signed [32:0] ex;
		logic signed [32:0] ey;
		sqrt_st_t           lx;
		sqrt_st_t           le;
	} len_st_t;

	logic [SQ_STG-1:0] vld_s;
	len_st_t           st_s [SQ_STG];
	len_st_t           init;

	function automatic len_st_t advance(len_st_t s, int base);
		len_st_t r;
		r = s;
		for (int k = 0; k < SQ_PER; k++) begin
			if (base + k < SQ_STEPS) begin
				r.lx = sqrt_step(r.lx);
				r.le = sqrt_step(r.le);
			end
		end
		return r;
	endfunction

	always_comb begin
		init.pay     = in_data.pay;
		init.xx      = in_data.xx;
		init.xy      = in_data.xy;
		init.ex      = in_data.ex;
		init.ey      = in_data.ey;
		init.lx.rad  = in_data.rad_x;
		init.lx.rem  = '0;
		init.lx.root = '0;
		init.le.rad  = in_data.rad_e;
		init.le.rem  = '0;
		init.le.root = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[SQ_STG-2:0], in_vld};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_s[0] <= advance(init, 0);
			for (int i = 1; i < SQ_STG; i++) begin
				st_s[i] <= advance(st_s[i-1], i * SQ_PER);
			end
		end
	end

	assign out_vld        = vld_s[SQ_STG-1];
	assign out_data.pay   = st_s[SQ_STG-1].pay;
	assign out_data.xx    = st_s[SQ_STG-1].xx;
	assign out_data.xy    = st_s[SQ_STG-1].xy;
	assign out_data.ex    = st_s[SQ_STG-1].ex;
	assign out_data.ey    = st_s[SQ_STG-1].ey;
	assign out_data.len_x = st_s[SQ_STG-1].lx.root;
	assign out_data.len_e = st_s[SQ_STG-1].le.root;

endmodule

@@ rtl/qcm_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qcm_unit
// Unit edge vectors: four rounded divisions by the edge lengths.
// ----------------------------------------------------------------------------
module qcm_unit import qcm_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   en,
	input  logic   in_vld,
	input  lens_t  in_data,
	output logic   out_vld,
	output units_t out_data
);

	typedef struct packed {
		cell_pay_t         pay;
		logic [31:0]       len_x;
		logic [31:0]       len_e;
		logic              zx;
		logic              ze;
		logic [3:0]        neg;
		div_st_t [3:0]     d;
	} unit_st_t;

	localparam int NV = UN_STG + 2;

	logic [NV-1:0] vld_s;
	unit_st_t      pre_s1;
	unit_st_t      dv_s [UN_STG];
	units_t        res_s;
	unit_st_t      pre;
	units_t        fin;

	function automatic unit_st_t advance(unit_st_t s, int base);
		unit_st_t r;
		r = s;
		for (int k = 0; k < DV_PER; k++) begin
			if (base + k < UN_STEPS) begin
				for (int l = 0; l < 4; l++) begin
					r.d[l] = div_step(r.d[l]);
				end
			end
		end
		return r;
	endfunction

	// (2*|c|*2^16 + L) / (2*L) gives round half away from zero
	function automatic div_st_t setup(logic signed [32:0] c, logic [RT_W-1:0] len);
		div_st_t     r;
		logic [32:0] m;
		logic [50:0] n;
		m     = c[32] ? 33'(-c) : 33'(c);
		n     = 51'({m, 17'b0}) + 51'(len);
		r.rem = DV_W'(n[50:17]);
		r.num = {n[16:0], 15'b0};
		r.den = DV_W'({len, 1'b0});
		r.q   = '0;
		return r;
	endfunction

	function automatic logic signed [17:0] finish(div_st_t d, logic neg, logic zero);
		logic signed [17:0] m;
		m = $signed({1'b0, d.q[16:0]});
		if (zero) begin
			return '0;
		end else if (neg) begin
			return -m;
		end
		return m;
	endfunction

	function automatic logic [31:0] sat_len(logic [RT_W-1:0] len);
		return (len[RT_W-1] || len[31]) ? SAT_MAX : len[31:0];
	endfunction

	always_comb begin
		pre.pay   = in_data.pay;
		pre.len_x = sat_len(in_data.len_x);
		pre.len_e = sat_len(in_data.len_e);
		pre.zx    = (in_data.len_x == '0);
		pre.ze    = (in_data.len_e == '0);
		pre.neg   = {in_data.ey[32], in_data.ex[32], in_data.xy[32], in_data.xx[32]};
		pre.d[0]  = setup(in_data.xx, in_data.len_x);
		pre.d[1]  = setup(in_data.xy, in_data.len_x);
		pre.d[2]  = setup(in_data.ex, in_data.len_e);
		pre.d[3]  = setup(in_data.ey, in_data.len_e);
	end

	always_comb begin
		fin.pay   = dv_s[UN_STG-1].pay;
		fin.len_x = dv_s[UN_STG-1].len_x;
		fin.len_e = dv_s[UN_STG-1].len_e;
		fin.uxx   = finish(dv_s[UN_STG-1].d[0], dv_s[UN_STG-1].neg[0], dv_s[UN_STG-1].zx);
		fin.uxy   = finish(dv_s[UN_STG-1].d[1], dv_s[UN_STG-1].neg[1], dv_s[UN_STG-1].zx);
		fin.uex   = finish(dv_s[UN_STG-1].d[2], dv_s[UN_STG-1].neg[2], dv_s[UN_STG-1].ze);
		fin.uey   = finish(dv_s[UN_STG-1].d[3], dv_s[UN_STG-1].neg[3], dv_s[UN_STG-1].ze);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[NV-2:0], in_vld};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pre_s1  <= pre;
			dv_s[0] <= advance(pre_s1, 0);
			for (int i = 1; i < UN_STG; i++) begin
				dv_s[i] <= advance(dv_s[i-1], i * DV_PER);
			end
			res_s   <= fin;
		end
	end

	assign out_vld  = vld_s[NV-1];
	assign out_data = res_s;

endmodule

@@ rtl/qcm_inv.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qcm_inv
// Determinant of the unit vector matrix and its saturated inverse.
// ----------------------------------------------------------------------------
module qcm_inv import qcm_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   en,
	input  logic   in_vld,
	input  units_t in_data,
	output logic   out_vld,
	output res_t   out_data
);

	typedef struct packed {
		units_t        u;
		logic          det0;
		logic [3:0]    neg;
		logic [3:0]    ovf;
		div_st_t [3:0] d;
	} inv_st_t;

	localparam int NV = IV_STG + 4;

	logic [NV-1:0]      vld_s;
	logic signed [35:0] p1_s1, p2_s1;
	units_t             u_s1, u_s2;
	logic signed [36:0] det_s2;
	inv_st_t            pre_s3;
	inv_st_t            dv_s [IV_STG];
	res_t               res_s;

	inv_st_t            pre;
	res_t               fin;
	logic [36:0]        det_mag;
	logic               det_neg;

	function automatic inv_st_t advance(inv_st_t s, int base);
		inv_st_t r;
		r = s;
		for (int k = 0; k < DV_PER; k++) begin
			if (base + k < IV_STEPS) begin
				for (int l = 0; l < 4; l++) begin
					r.d[l] = div_step(r.d[l]);
				end
			end
		end
		return r;
	endfunction

	// (2*|u|*2^32 + |D|) / (2*|D|), quotient overflow flagged up front
	function automatic div_st_t setup(logic signed [17:0] u, logic [36:0] dm, output logic ovf);
		div_st_t     r;
		logic [16:0] m;
		logic [50:0] n;
		m     = u[17] ? 17'(-u) : 17'(u);
		n     = 51'({m, 33'b0}) + 51'(dm);
		r.den = DV_W'({dm, 1'b0});
		r.rem = DV_W'(n[50:32]);
		r.num = n[31:0];
		r.q   = '0;
		ovf   = (DV_W'(n[50:32]) >= r.den);
		return r;
	endfunction

	function automatic logic [31:0] finish(div_st_t d, logic neg, logic ovf, logic zero);
		if (zero) begin
			return '0;
		end else if (neg) begin
			return (ovf || d.q > SAT_MIN) ? SAT_MIN : -d.q;
		end
		return (ovf || d.q[31]) ? SAT_MAX : d.q;
	endfunction

	always_comb begin
		det_neg  = det_s2[36];
		det_mag  = det_neg ? 37'(-det_s2) : 37'(det_s2);
		pre.u    = u_s2;
		pre.det0 = (det_s2 == '0);
		// sign of each numerator: ey, -ex, -uy, ux
		pre.neg[0] = (u_s2.uey < 0) ^ det_neg;
		pre.neg[1] = (u_s2.uex > 0) ^ det_neg;
		pre.neg[2] = (u_s2.uxy > 0) ^ det_neg;
		pre.neg[3] = (u_s2.uxx < 0) ^ det_neg;
		pre.d[0] = setup(u_s2.uey, det_mag, pre.ovf[0]);
		pre.d[1] = setup(u_s2.uex, det_mag, pre.ovf[1]);
		pre.d[2] = setup(u_s2.uxy, det_mag, pre.ovf[2]);
		pre.d[3] = setup(u_s2.uxx, det_mag, pre.ovf[3]);
	end

	always_comb begin
		fin.u     = dv_s[IV_STG-1].u;
		fin.degen = dv_s[IV_STG-1].det0;
		for (int l = 0; l < 4; l++) begin
			fin.inv[l] = finish(dv_s[IV_STG-1].d[l], dv_s[IV_STG-1].neg[l],
				dv_s[IV_STG-1].ovf[l], dv_s[IV_STG-1].det0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[NV-2:0], in_vld};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p1_s1   <= 36'(in_data.uxx) * 36'(in_data.uey);
			p2_s1   <= 36'(in_data.uex) * 36'(in_data.uxy);
			u_s1    <= in_data;
			det_s2  <= 37'(p1_s1) - 37'(p2_s1);
			u_s2    <= u_s1;
			pre_s3  <= pre;
			dv_s[0] <= advance(pre_s3, 0);
			for (int i = 1; i < IV_STG; i++) begin
				dv_s[i] <= advance(dv_s[i-1], i * DV_PER);
			end
			res_s   <= fin;
		end
	end

	assign out_vld  = vld_s[NV-1];
	assign out_data = res_s;

endmodule

@@ rtl/quad_cell_metrics.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quad_cell_metrics
// Geometric metrics of one quadrilateral grid cell, two result transfers per cell.
// ----------------------------------------------------------------------------
// Each input transfer carries four Q16.16 corners and produces two output
// transfers: first centroid, area, edge lengths and unit xi vector, then the
// unit eta vector and the inverse of the unit-vector matrix (tlast set). The
// datapath is a 38-stage pipeline that takes a cell every cycle while not stalled; the
// two-beat output register limits the sustained rate to one cell per two output beats,
// even with m_tready held high. A stall on the output freezes the whole pipeline.
module quad_cell_metrics import qcm_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// p00_x, p00_y, p10_x, p10_y, p01_x, p01_y, p11_x, p11_y
	input  logic [255:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// v0, v1, v2, v3, v4, v5, v6
	output logic [223:0] m_tdata,
	// part, degenerate
	output logic [1:0]   m_tuser,
	output logic         m_tlast
);

	logic     en;
	corners_t cin;
	logic     geo_vld, len_vld, unit_vld, res_vld;
	geo_t     geo;
	lens_t    lens;
	units_t   units;
	res_t     res;

	res_t     hold_q;
	logic     hold_vld_q;
	logic     phase_q;

	assign cin.p00_x = s_tdata[31:0];
	assign cin.p00_y = s_tdata[63:32];
	assign cin.p10_x = s_tdata[95:64];
	assign cin.p10_y = s_tdata[127:96];
	assign cin.p01_x = s_tdata[159:128];
	assign cin.p01_y = s_tdata[191:160];
	assign cin.p11_x = s_tdata[223:192];
	assign cin.p11_y = s_tdata[255:224];

	// pipeline moves unless the output register holds a cell whose second beat is not taken
	assign en       = !hold_vld_q || (m_tready && phase_q);
	assign s_tready = en;

	qcm_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (s_tvalid),
		.in_data  (cin),
		.out_vld  (geo_vld),
		.out_data (geo)
	);

	qcm_len u_len (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (geo_vld),
		.in_data  (geo),
		.out_vld  (len_vld),
		.out_data (lens)
	);

	qcm_unit u_unit (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (len_vld),
		.in_data  (lens),
		.out_vld  (unit_vld),
		.out_data (units)
	);

	qcm_inv u_inv (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (unit_vld),
		.in_data  (units),
		.out_vld  (res_vld),
		.out_data (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_vld_q <= 1'b0;
			phase_q    <= 1'b0;
		end else if (en) begin
			hold_vld_q <= res_vld;
			phase_q    <= 1'b0;
		end else if (m_tready) begin
			phase_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en && res_vld) begin
			hold_q <= res;
		end
	end

	assign m_tvalid = hold_vld_q;
	assign m_tlast  = phase_q;
	assign m_tuser  = {hold_q.degen, phase_q};

	always_comb begin
		if (phase_q) begin
			m_tdata = {32'b0, hold_q.inv[3], hold_q.inv[2], hold_q.inv[1], hold_q.inv[0],
				{{14{hold_q.u.uey[17]}}, hold_q.u.uey},
				{{14{hold_q.u.uex[17]}}, hold_q.u.uex}};
		end else begin
			m_tdata = {{{14{hold_q.u.uxy[17]}}, hold_q.u.uxy},
				{{14{hold_q.u.uxx[17]}}, hold_q.u.uxx},
				hold_q.u.len_e, hold_q.u.len_x, hold_q.u.pay.area,
				hold_q.u.pay.cen_y, hold_q.u.pay.cen_x};
		end
	end

	// the second beat of a cell always follows the first, same degenerate flag
	a_second_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && !m_tuser[0]) |=>
		(m_tvalid && m_tuser[0] && m_tuser[1] == $past(m_tuser[1])))
		else $error("second result beat missing or changed");

	// no new cell enters while the first beat is pending
	a_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser[0]) |-> !s_tready)
		else $error("input accepted while first beat pending");

	a_last_part: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tlast == m_tuser[0]))
		else $error("tlast does not mark the second beat");

endmodule
